// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the sorted priority queue: operation codes, word formats,
// one stored entry and the control word broadcast to every cell. No dependencies.
package spq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_DEQUEUE    = 2'd1,
    OP_PEEK_FRONT = 2'd2,
    OP_PEEK_REAR  = 2'd3
  } spq_op_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] task_id;
    logic [7:0] prio;
  } spq_in_t;

  typedef struct packed {
    logic [7:0] out_task;
    logic       out_valid;
    logic       insert_dropped;
    logic [3:0] occupancy;
  } spq_out_t;

  typedef struct packed {
    logic [7:0] task_id;
    logic [7:0] prio;
  } spq_entry_t;

  // Broadcast to all cells for the word being accepted in this cycle.
  typedef struct packed {
    logic       ins;
    logic       deq;
    spq_entry_t item;
  } spq_ctl_t;

endpackage

// ===== design/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Top level of the sorted priority queue: a chain of spq_cell slots, the count,
// the rear task id copy and the result register. Depends on spq_pkg and spq_cell.
//
//   channel | signals                     | direction | word
//   input   | in_valid, in_ready, in_data  | in        | spq_in_t
//   output  | out_valid, out_ready, out_data | out     | spq_out_t
//
// Every operation completes in the cycle its word is accepted; its result is
// registered and shows in the next cycle, so one word per cycle is sustained
// while out_ready is high. The chain shifts all slots in parallel, so depth
// does not change the rate. in_ready drops only while a result waits and
// out_ready is low. Reset empties the queue at once; no clearing pass is needed.
module sorted_priority_queue #(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  spq_pkg::spq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::spq_out_t out_data
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW+3:0]   occ_wide;
  logic [7:0]      rear_task;
  logic [7:0]      rear_task_next;
  logic            accept;
  logic            full;
  logic            empty;
  logic            any_gt;
  spq_ctl_t        ctl;
  spq_out_t        result;
  spq_entry_t      cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_gt;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign any_gt   = |cell_gt;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_e;
    spq_entry_t right_e;
    logic       left_g;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_g = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    spq_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .left_entry (left_e),
      .left_gt    (left_g),
      .right_entry(right_e),
      .entry      (cell_entry[i]),
      .gt         (cell_gt[i])
    );
  end

  always_comb begin
    ctl.ins          = 1'b0;
    ctl.deq          = 1'b0;
    ctl.item.task_id = in_data.task_id;
    ctl.item.prio    = in_data.prio;
    count_next       = count;
    rear_task_next   = rear_task;
    result           = '0;
    unique case (spq_op_t'(in_data.func))
      OP_INSERT: begin
        if (full) begin
          result.insert_dropped = 1'b1;
        end else begin
          ctl.ins    = accept;
          count_next = count + CW'(1);
          // The rear changes only when the new entry lands past every stored one.
          if (!any_gt) begin
            rear_task_next = in_data.task_id;
          end
        end
      end
      OP_DEQUEUE: begin
        if (!empty) begin
          ctl.deq          = accept;
          count_next       = count - CW'(1);
          result.out_task  = cell_entry[0].task_id;
          result.out_valid = 1'b1;
        end
      end
      OP_PEEK_FRONT: begin
        if (!empty) begin
          result.out_task  = cell_entry[0].task_id;
          result.out_valid = 1'b1;
        end
      end
      OP_PEEK_REAR: begin
        if (!empty) begin
          result.out_task  = rear_task;
          result.out_valid = 1'b1;
        end
      end
      default: begin
        result = '0;
      end
    endcase
    occ_wide         = {4'b0000, count_next};
    result.occupancy = occ_wide[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rear_task <= rear_task_next;
      out_data  <= result;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.func == OP_INSERT) && full
    |=> out_data.insert_dropped && $stable(count))
    else $error("insert into full queue not dropped");

  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.func == OP_DEQUEUE) && !empty
    |=> (count == $past(count) - CW'(1)) && out_data.out_valid)
    else $error("dequeue did not remove an entry");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
    else $error("head entries out of order");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

// ===== design/spq_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic               clk,
  input  spq_pkg::spq_ctl_t  ctl,
  input  logic [CW-1:0]      count,
  input  spq_pkg::spq_entry_t left_entry,
  input  logic               left_gt,
  input  spq_pkg::spq_entry_t right_entry,
  output spq_pkg::spq_entry_t entry,
  output logic               gt
);
  import spq_pkg::*;

  logic       occupied;
  logic       is_tail;
  spq_entry_t entry_next;

  assign occupied = count > CW'(IDX);
  assign is_tail  = count == CW'(IDX);

  // A stored entry with a strictly larger priority moves up for the new one.
  assign gt = occupied && (entry.prio > ctl.item.prio);

  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (left_gt) begin
        entry_next = left_entry;
      end else if (gt || is_tail) begin
        entry_next = ctl.item;
      end
    end else if (ctl.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
